// ===== hdl/cpu_flow_control_unit_macros.svh =====
// Assertion macros for the program-flow unit.
// Used by the top level; no other dependencies.
`ifndef CPU_FLOW_CONTROL_UNIT_MACROS_SVH
`define CPU_FLOW_CONTROL_UNIT_MACROS_SVH
`ifndef SYNTH
`define CFU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flow unit check failed");
`define CFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flow unit check failed");
`else
`define CFU_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CFU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/cfu_pkg.sv =====
// Shared types, codes and condition logic for the program-flow unit.
// No dependencies.
package cfu_pkg;

    typedef struct packed {
        logic [15:0] opcode;
        logic [23:0] pc;
        logic [15:0] ext_word;
        logic [15:0] status_reg;
        logic [15:0] counter_in;
        logic [31:0] stack_ptr;
        logic [23:0] ea_address;
        logic [15:0] popped_word;
        logic [31:0] popped_long;
    } req_t;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_PRIV  = 2'd1,
        FAULT_ILLEG = 2'd2
    } fault_t;

    typedef struct packed {
        logic [23:0] next_pc;
        logic        used_ext_word;
        logic [15:0] counter_out;
        logic        counter_write;
        logic [31:0] stack_ptr_out;
        logic        push_write;
        logic [23:0] push_address;
        logic [23:0] push_data;
        logic [15:0] status_reg_out;
        logic [7:0]  set_byte;
        fault_t      fault;
    } rsp_t;

    // Opcode patterns
    localparam logic [15:0] BCC_MASK  = 16'hF000;
    localparam logic [15:0] BCC_CODE  = 16'h6000;
    localparam logic [15:0] DBCC_MASK = 16'hF0F8;
    localparam logic [15:0] DBCC_CODE = 16'h50C8;
    localparam logic [15:0] SCC_MASK  = 16'hF0C0;
    localparam logic [15:0] SCC_CODE  = 16'h50C0;
    localparam logic [15:0] JMP_MASK  = 16'hFF80;
    localparam logic [15:0] JMP_CODE  = 16'h4E80;
    localparam logic [15:0] OP_RTS    = 16'h4E75;
    localparam logic [15:0] OP_RTE    = 16'h4E73;
    localparam logic [15:0] OP_RTR    = 16'h4E77;

    // Addressing modes
    localparam logic [2:0] MODE_IND  = 3'd2;
    localparam logic [2:0] MODE_DISP = 3'd5;
    localparam logic [2:0] MODE_IDX  = 3'd6;
    localparam logic [2:0] MODE_EXT  = 3'd7;

    // Condition codes
    localparam logic [3:0] CC_T  = 4'd0;
    localparam logic [3:0] CC_F  = 4'd1;
    localparam logic [3:0] CC_HI = 4'd2;
    localparam logic [3:0] CC_LS = 4'd3;
    localparam logic [3:0] CC_CC = 4'd4;
    localparam logic [3:0] CC_CS = 4'd5;
    localparam logic [3:0] CC_NE = 4'd6;
    localparam logic [3:0] CC_EQ = 4'd7;
    localparam logic [3:0] CC_VC = 4'd8;
    localparam logic [3:0] CC_VS = 4'd9;
    localparam logic [3:0] CC_PL = 4'd10;
    localparam logic [3:0] CC_MI = 4'd11;
    localparam logic [3:0] CC_GE = 4'd12;
    localparam logic [3:0] CC_LT = 4'd13;
    localparam logic [3:0] CC_GT = 4'd14;

    localparam int SR_SUPER_BIT = 13;

    // Evaluate a condition on the NZVC flags (bits 3..0 of SR).
    function automatic logic cond_true(input logic [3:0] cc, input logic [3:0] flags);
        logic c;
        logic v;
        logic z;
        logic n;
        logic res;
        c = flags[0];
        v = flags[1];
        z = flags[2];
        n = flags[3];
        case (cc)
            CC_T:    res = 1'b1;
            CC_F:    res = 1'b0;
            CC_HI:   res = !c && !z;
            CC_LS:   res = c || z;
            CC_CC:   res = !c;
            CC_CS:   res = c;
            CC_NE:   res = !z;
            CC_EQ:   res = z;
            CC_VC:   res = !v;
            CC_VS:   res = v;
            CC_PL:   res = !n;
            CC_MI:   res = n;
            CC_GE:   res = (n == v);
            CC_LT:   res = (n != v);
            CC_GT:   res = !z && (n == v);
            default: res = z || (n != v);
        endcase
        return res;
    endfunction

endpackage

// ===== hdl/cfu_stream_if.sv =====
// Valid/ready channel used by the program-flow unit.
// Payload type is supplied by the instance (see cfu_pkg).
interface cfu_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/cpu_flow_control_unit.sv =====
// Program-flow unit: executes one branch/jump/return or Scc instruction per request.
// Depends on cfu_pkg, cfu_stream_if and cpu_flow_control_unit_macros.svh.
//
//  channel | modport | payload      | role
//  --------+---------+--------------+-------------------------------------
//  req     | sink    | cfu_pkg::req_t | instruction word plus operands
//  rsp     | source  | cfu_pkg::rsp_t | next PC, SP, push, SR, counter, fault
//
// One request per cycle sustained while rsp is taken; an accepted request
// goes to the input register and its result to the result register, with the
// decode, the 32-bit adders and the condition test in one pass between them.
// Reset (rst_n low, asynchronous) empties both stages; payloads are not reset.
// A stalled rsp holds its result; the input stage still fills, and req.ready
// drops only when both stages are full and rsp is not taken.
`include "cpu_flow_control_unit_macros.svh"

module cpu_flow_control_unit #(
    parameter int ADDR_BITS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    cfu_stream_if.sink   req,
    cfu_stream_if.source rsp
);

    // Address mask, low 24 bits are all that reach the ports
    localparam logic [63:0] MASK_WIDE = (64'd1 << ADDR_BITS) - 64'd1;
    localparam logic [23:0] MASK24    = MASK_WIDE[23:0];

    // ------------------------------------------------------------------
    // Stage registers and flow control
    // ------------------------------------------------------------------
    cfu_pkg::req_t s1_reg;
    logic          s1_valid_reg;
    cfu_pkg::rsp_t rsp_reg;
    cfu_pkg::rsp_t rsp_next;
    logic          rsp_valid_reg;

    logic s2_load;
    logic s1_load;

    // Result register takes a new value whenever it is empty or drained.
    assign s2_load   = !rsp_valid_reg || rsp.ready;
    // Input register fills when empty or when its content moves on.
    assign req.ready = !s1_valid_reg || s2_load;
    assign s1_load   = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_load)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg <= req.payload;
        end
        if (s2_load && s1_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    // ------------------------------------------------------------------
    // Execute: decode and compute the result of the held instruction
    // ------------------------------------------------------------------
    logic [15:0] op;
    logic [3:0]  cc;
    logic [2:0]  mode;
    logic [2:0]  rg;
    logic        cond;
    logic [31:0] pc32;
    logic [31:0] disp;
    logic [31:0] after;
    logic [31:0] npc;
    logic [31:0] sp_push;
    logic [15:0] cnt_dec;
    logic        scc_mode_ok;
    logic        jmp_mode_ok;

    assign op          = s1_reg.opcode;
    assign cc          = op[11:8];
    assign mode        = op[5:3];
    assign rg          = op[2:0];
    assign cond        = cfu_pkg::cond_true(cc, s1_reg.status_reg[3:0]);
    assign pc32        = {8'd0, s1_reg.pc};
    assign sp_push     = s1_reg.stack_ptr - 32'd4;
    assign cnt_dec     = s1_reg.counter_in - 16'd1;
    // Scc rejects immediate and PC-relative destinations
    assign scc_mode_ok = !(mode == cfu_pkg::MODE_EXT && rg > 3'd1);
    // JMP/JSR take control addressing modes only
    assign jmp_mode_ok = (mode == cfu_pkg::MODE_IND) || (mode == cfu_pkg::MODE_DISP)
                      || (mode == cfu_pkg::MODE_IDX)
                      || (mode == cfu_pkg::MODE_EXT && rg < 3'd4);

    always_comb
    begin
        // Short displacement in the opcode, else the extension word.
        if (op[7:0] != 8'd0)
        begin
            disp  = {{24{op[7]}}, op[7:0]};
            after = pc32;
        end
        else
        begin
            disp  = {{16{s1_reg.ext_word[15]}}, s1_reg.ext_word};
            after = pc32 + 32'd2;
        end
    end

    always_comb
    begin
        npc                     = pc32;
        rsp_next.used_ext_word  = 1'b0;
        rsp_next.counter_out    = s1_reg.counter_in;
        rsp_next.counter_write  = 1'b0;
        rsp_next.stack_ptr_out  = s1_reg.stack_ptr;
        rsp_next.push_write     = 1'b0;
        rsp_next.push_address   = 24'd0;
        rsp_next.push_data      = 24'd0;
        rsp_next.status_reg_out = s1_reg.status_reg;
        rsp_next.set_byte       = 8'd0;
        rsp_next.fault          = cfu_pkg::FAULT_NONE;

        if ((op & cfu_pkg::BCC_MASK) == cfu_pkg::BCC_CODE)
        begin
            // BRA / BSR / Bcc
            rsp_next.used_ext_word = (op[7:0] == 8'd0);
            if (cc == cfu_pkg::CC_F)
            begin
                // BSR: push the return address
                rsp_next.stack_ptr_out = sp_push;
                rsp_next.push_write    = 1'b1;
                rsp_next.push_address  = sp_push[23:0] & MASK24;
                rsp_next.push_data     = after[23:0] & MASK24;
                npc                    = pc32 + disp;
            end
            else if (cond)
            begin
                npc = pc32 + disp;
            end
            else
            begin
                npc = after;
            end
        end
        else if ((op & cfu_pkg::DBCC_MASK) == cfu_pkg::DBCC_CODE)
        begin
            // DBcc: if the condition is false, decrement and loop unless the counter hits -1
            rsp_next.used_ext_word = 1'b1;
            npc                    = pc32 + 32'd2;
            if (!cond)
            begin
                rsp_next.counter_out   = cnt_dec;
                rsp_next.counter_write = 1'b1;
                if (cnt_dec != 16'hFFFF)
                begin
                    npc = pc32 + {{16{s1_reg.ext_word[15]}}, s1_reg.ext_word};
                end
            end
        end
        else if ((op & cfu_pkg::SCC_MASK) == cfu_pkg::SCC_CODE && scc_mode_ok)
        begin
            rsp_next.set_byte = cond ? 8'hFF : 8'h00;
        end
        else if ((op & cfu_pkg::JMP_MASK) == cfu_pkg::JMP_CODE && jmp_mode_ok)
        begin
            // JSR when bit 6 is clear, JMP when set
            if (!op[6])
            begin
                rsp_next.stack_ptr_out = sp_push;
                rsp_next.push_write    = 1'b1;
                rsp_next.push_address  = sp_push[23:0] & MASK24;
                rsp_next.push_data     = s1_reg.pc & MASK24;
            end
            npc = {8'd0, s1_reg.ea_address};
        end
        else if (op == cfu_pkg::OP_RTS)
        begin
            npc                    = s1_reg.popped_long;
            rsp_next.stack_ptr_out = s1_reg.stack_ptr + 32'd4;
        end
        else if (op == cfu_pkg::OP_RTE)
        begin
            if (!s1_reg.status_reg[cfu_pkg::SR_SUPER_BIT])
            begin
                rsp_next.fault = cfu_pkg::FAULT_PRIV;
            end
            else
            begin
                rsp_next.status_reg_out = s1_reg.popped_word;
                npc                     = s1_reg.popped_long;
                rsp_next.stack_ptr_out  = s1_reg.stack_ptr + 32'd6;
            end
        end
        else if (op == cfu_pkg::OP_RTR)
        begin
            // RTR restores the condition code byte only
            rsp_next.status_reg_out = {s1_reg.status_reg[15:8], s1_reg.popped_word[7:0]};
            npc                     = s1_reg.popped_long;
            rsp_next.stack_ptr_out  = s1_reg.stack_ptr + 32'd6;
        end
        else
        begin
            rsp_next.fault = cfu_pkg::FAULT_ILLEG;
        end

        rsp_next.next_pc = npc[23:0] & MASK24;
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `CFU_ASSERT_IMPLY(a_fault_quiet, clk, rst_n,
        rsp.valid && rsp.payload.fault != cfu_pkg::FAULT_NONE,
        !rsp.payload.push_write && !rsp.payload.counter_write && rsp.payload.set_byte == 8'd0)
    `CFU_ASSERT_IMPLY(a_push_addr, clk, rst_n,
        rsp.valid && rsp.payload.push_write,
        rsp.payload.push_address == (rsp.payload.stack_ptr_out[23:0] & MASK24))
    `CFU_ASSERT_IMPLY(a_count_ext, clk, rst_n,
        rsp.valid && rsp.payload.counter_write,
        rsp.payload.used_ext_word)
    `CFU_ASSERT_NEXT(a_hold_stage1, clk, rst_n,
        s1_valid_reg && !s2_load,
        s1_valid_reg && $stable(s1_reg))

endmodule
